// ===== rtl/core/imusq_pkg.sv =====
// ----------------------------------------------------------------------------
// imusq_pkg
// Shared widths, status codes, register indexes and reset values for the
// IMU sample qualifier and its sample ring.
// ----------------------------------------------------------------------------
package imusq_pkg;

    localparam int IMUSQ_DEPTH = 32;

    localparam int RAW_W   = 16;
    localparam int VAL_W   = 17;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;
    localparam int ENTRY_W = TIME_W + 6 * VAL_W;

    // result status codes
    localparam logic [2:0] ST_WARMUP = 3'd0;
    localparam logic [2:0] ST_JUNK   = 3'd1;
    localparam logic [2:0] ST_STORED = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_WARMUP_COUNT   = 2'd0;
    localparam logic [1:0] REG_ACCEL_SQ_LIMIT = 2'd1;
    localparam logic [1:0] REG_GYRO_ABS_LIMIT = 2'd2;

    localparam logic [7:0]  WARMUP_COUNT_RST   = 8'd20;
    localparam logic [31:0] ACCEL_SQ_LIMIT_RST = 32'd2684355;
    localparam logic [15:0] GYRO_ABS_LIMIT_RST = 16'd13100;

endpackage

// ===== rtl/core/imu_sample_qualifier_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// imu_sample_qualifier_fifo_unit
// IMU sample qualifier with a DEPTH-entry sample ring held in one RAM.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. It runs in
// two steps: the accept cycle, in which the accel squares are registered and
// the ring RAM read is issued, and the execute cycle, in which the sum is
// compared, the RAM is written and the result is registered. done then pulses
// for one cycle with the result; the receiver cannot stall it, so it must take
// the result in that cycle. busy is already low while done is high, so a new
// start may be given while done is high. The RAM powers up undefined and
// needs no clearing pass; a pop only reaches entries that a push has written.
// ----------------------------------------------------------------------------
module imu_sample_qualifier_fifo_unit
    import imusq_pkg::*;
#(
    parameter int DEPTH = IMUSQ_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    command,
    input  logic signed [RAW_W-1:0] raw_accel_x,
    input  logic signed [RAW_W-1:0] raw_accel_y,
    input  logic signed [RAW_W-1:0] raw_accel_z,
    input  logic signed [RAW_W-1:0] raw_gyro_x,
    input  logic signed [RAW_W-1:0] raw_gyro_y,
    input  logic signed [RAW_W-1:0] raw_gyro_z,
    input  logic [TIME_W-1:0]       time_ms,
    output logic                    done,
    output logic [2:0]              status,
    output logic [TIME_W-1:0]       sample_time,
    output logic signed [VAL_W-1:0] accel_x,
    output logic signed [VAL_W-1:0] accel_y,
    output logic signed [VAL_W-1:0] accel_z,
    output logic signed [VAL_W-1:0] gyro_x,
    output logic signed [VAL_W-1:0] gyro_y,
    output logic signed [VAL_W-1:0] gyro_z,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        r = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
        return r;
    endfunction

    state_t            state_reg;
    logic              done_reg;
    logic [2:0]        status_reg;
    logic [TIME_W-1:0] sample_time_reg;
    logic [VAL_W-1:0]  out_reg [6];
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [7:0]        warmup_left_reg;

    logic [31:0]       accel_sq_limit_reg;
    logic [15:0]       gyro_abs_limit_reg;

    logic              cmd_reg;
    logic [TIME_W-1:0] time_reg;
    logic [VAL_W-1:0]  smp_reg [6];

    logic              accept;
    logic              junk;
    logic [IDX_W-1:0]  wr_next;
    logic [IDX_W-1:0]  rd_next;
    logic              ram_we;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic              push_go;
    logic              ring_empty;
    logic [VAL_W-1:0]  ay_neg;
    logic [VAL_W-1:0]  gy_neg;

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign wr_next    = idx_inc(wr_idx_reg);
    assign rd_next    = idx_inc(rd_idx_reg);
    assign ring_empty = (rd_idx_reg == wr_idx_reg);
    assign push_go    = (warmup_left_reg == 8'd0) && !junk;

    assign ay_neg = VAL_W'(0) - {raw_accel_y[RAW_W-1], raw_accel_y};
    assign gy_neg = VAL_W'(0) - {raw_gyro_y[RAW_W-1], raw_gyro_y};

    // RAM writes land at the end of the execute cycle, before any later accept
    // can issue a read, so busy is the only interlock needed
    assign ram_re    = accept && (command == CMD_POP);
    assign ram_we    = (state_reg == S_RUN) && (cmd_reg == CMD_PUSH) && push_go;
    assign ram_wdata = {time_reg, smp_reg[0], smp_reg[1], smp_reg[2],
                        smp_reg[3], smp_reg[4], smp_reg[5]};

    imusq_qual u_qual (
        .clk            (clk),
        .rst_n          (rst_n),
        .capture        (accept),
        .raw_accel_x    (raw_accel_x),
        .raw_accel_y    (raw_accel_y),
        .raw_accel_z    (raw_accel_z),
        .raw_gyro_x     (raw_gyro_x),
        .raw_gyro_y     (raw_gyro_y),
        .raw_gyro_z     (raw_gyro_z),
        .accel_sq_limit (accel_sq_limit_reg),
        .gyro_abs_limit (gyro_abs_limit_reg),
        .junk           (junk)
    );

    imusq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_next),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_next),
        .rdata (ram_rdata)
    );

    // the warmup count only reloads warmup_left_reg, handled below
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_sq_limit_reg <= ACCEL_SQ_LIMIT_RST;
            gyro_abs_limit_reg <= GYRO_ABS_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACCEL_SQ_LIMIT: accel_sq_limit_reg <= cfg_data[31:0];
                REG_GYRO_ABS_LIMIT: gyro_abs_limit_reg <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            time_reg   <= time_ms;
            smp_reg[0] <= {raw_accel_x[RAW_W-1], raw_accel_x};
            smp_reg[1] <= ay_neg;
            smp_reg[2] <= {raw_accel_z[RAW_W-1], raw_accel_z};
            smp_reg[3] <= {raw_gyro_x[RAW_W-1], raw_gyro_x};
            smp_reg[4] <= gy_neg;
            smp_reg[5] <= {raw_gyro_z[RAW_W-1], raw_gyro_z};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            status_reg      <= ST_WARMUP;
            sample_time_reg <= '0;
            for (int j = 0; j < 6; j++)
            begin
                out_reg[j] <= '0;
            end
            wr_idx_reg      <= '0;
            rd_idx_reg      <= '0;
            warmup_left_reg <= WARMUP_COUNT_RST;
        end
        else
        begin
            done_reg <= 1'b0;
            // writing the warmup count also restarts the warmup
            if (cfg_we && (cfg_index == REG_WARMUP_COUNT))
            begin
                warmup_left_reg <= cfg_data[7:0];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    state_reg       <= S_IDLE;
                    done_reg        <= 1'b1;
                    sample_time_reg <= '0;
                    for (int j = 0; j < 6; j++)
                    begin
                        out_reg[j] <= '0;
                    end
                    if (cmd_reg == CMD_PUSH)
                    begin
                        if (warmup_left_reg != 8'd0)
                        begin
                            warmup_left_reg <= warmup_left_reg - 8'd1;
                            status_reg      <= ST_WARMUP;
                        end
                        else if (junk)
                        begin
                            status_reg <= ST_JUNK;
                        end
                        else
                        begin
                            wr_idx_reg <= wr_next;
                            status_reg <= ST_STORED;
                        end
                    end
                    else if (ring_empty)
                    begin
                        status_reg <= ST_EMPTY;
                    end
                    else
                    begin
                        rd_idx_reg      <= rd_next;
                        status_reg      <= ST_READ;
                        sample_time_reg <= ram_rdata[ENTRY_W-1 -: TIME_W];
                        for (int j = 0; j < 6; j++)
                        begin
                            out_reg[j] <= ram_rdata[(6-j)*VAL_W-1 -: VAL_W];
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign sample_time = sample_time_reg;
    assign accel_x     = out_reg[0];
    assign accel_y     = out_reg[1];
    assign accel_z     = out_reg[2];
    assign gyro_x      = out_reg[3];
    assign gyro_y      = out_reg[4];
    assign gyro_z      = out_reg[5];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result not delivered two cycles after accept");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_READ) |->
            (sample_time == '0 && accel_x == '0 && accel_y == '0 &&
             accel_z == '0 && gyro_x == '0 && gyro_y == '0 && gyro_z == '0))
        else $error("sample fields not zero on a non-read result");

    a_wr_move: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_idx_reg != $past(wr_idx_reg)) |-> (done_reg && status_reg == ST_STORED))
        else $error("write index moved without a stored result");

    a_rd_move: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_idx_reg != $past(rd_idx_reg)) |-> (done_reg && status_reg == ST_READ))
        else $error("read index moved without a read result");

endmodule

// ===== rtl/core/imusq_ram.sv =====
// ----------------------------------------------------------------------------
// imusq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module imusq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/imusq_qual.sv =====
// ----------------------------------------------------------------------------
// imusq_qual
// Sample qualifier: squares the accel magnitudes and checks gyro magnitudes
// in the accept cycle, then sums and compares in the following cycle.
// ----------------------------------------------------------------------------
module imusq_qual
    import imusq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    capture,
    input  logic signed [RAW_W-1:0] raw_accel_x,
    input  logic signed [RAW_W-1:0] raw_accel_y,
    input  logic signed [RAW_W-1:0] raw_accel_z,
    input  logic signed [RAW_W-1:0] raw_gyro_x,
    input  logic signed [RAW_W-1:0] raw_gyro_y,
    input  logic signed [RAW_W-1:0] raw_gyro_z,
    input  logic [31:0]             accel_sq_limit,
    input  logic [15:0]             gyro_abs_limit,
    output logic                    junk
);

    // magnitude of a 16-bit two's complement value; -32768 gives 32768
    function automatic logic [RAW_W-1:0] mag(input logic signed [RAW_W-1:0] v);
        logic [RAW_W-1:0] r;
        r = v[RAW_W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    logic [RAW_W-1:0] am [3];
    logic [RAW_W-1:0] gm [3];
    logic [31:0]      sq_next [3];
    logic [31:0]      sq_reg [3];
    logic             wild_next;
    logic             wild_reg;
    logic [31:0]      sq_sum;

    // negation does not change a magnitude, so the raw y axes serve as is
    always_comb
    begin
        am[0] = mag(raw_accel_x);
        am[1] = mag(raw_accel_y);
        am[2] = mag(raw_accel_z);
        gm[0] = mag(raw_gyro_x);
        gm[1] = mag(raw_gyro_y);
        gm[2] = mag(raw_gyro_z);
        for (int j = 0; j < 3; j++)
        begin
            sq_next[j] = 32'(am[j]) * 32'(am[j]);
        end
        wild_next = (gm[0] > gyro_abs_limit) || (gm[1] > gyro_abs_limit) ||
                    (gm[2] > gyro_abs_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wild_reg <= 1'b0;
        end
        else if (capture)
        begin
            wild_reg <= wild_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            sq_reg <= sq_next;
        end
    end

    // each square is at most 2^30, so three of them fit in 32 bits
    assign sq_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];
    assign junk   = (sq_sum < accel_sq_limit) && wild_reg;

endmodule
